@@ design/bchd_pkg.sv @@
// Package: payload structs, register map and reset constants for the button detector.
package bchd_pkg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        pin_level;
    } sample_t;

    typedef struct packed {
        logic        rise_edge;
        logic        fall_edge;
        logic        click_one;
        logic        click_two;
        logic        click_three;
        logic        hold_once;
        logic        hold_every;
        logic        idle_once;
        logic        idle_every;
        logic        pressed_now;
        logic [31:0] released_time;
        logic [31:0] held_time;
    } event_t;

    localparam int unsigned ADDR_W = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ACTIVE_LOW   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_MS  = 2'd1;
    localparam logic [1:0] REG_CLICK_GAP_MS = 2'd2;
    localparam logic [1:0] REG_HOLD_MS      = 2'd3;

    localparam logic        RST_ACTIVE_LOW   = 1'b1;
    localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
    localparam logic [15:0] RST_CLICK_GAP_MS = 16'd400;
    localparam logic [15:0] RST_HOLD_MS      = 16'd1000;

    localparam logic [1:0] CLICK_NONE  = 2'd0;
    localparam logic [1:0] CLICK_ONE   = 2'd1;
    localparam logic [1:0] CLICK_TWO   = 2'd2;
    localparam logic [1:0] CLICK_THREE = 2'd3;
    localparam logic [1:0] CLICK_MAX   = CLICK_THREE;

endpackage

@@ design/button_click_hold_detector.sv @@
// Top level: debounced button click and hold detector with APB register port.
//
// Usage:
//   s_valid/s_ready/s_payload carry one pin sample per transaction: a wrapping
//   millisecond timestamp and the raw pin level. Every sample yields exactly one
//   result transaction on m_valid/m_ready/m_payload with per-sample event flags
//   (edges, clicks, hold and not-held) plus the held and released times.
//   A sample accepted is captured in the input register; its result is
//   loaded into the output register, raising m_valid, once that register
//   is empty or being read. Throughput is one sample per cycle unless the
//   receiver stalls, set by the single compare/subtract pass on the state.
//   When the receiver stalls, the result holds in the output register and one
//   more sample waits in the input register; s_ready then drops.
//   Reset (aresetn low, synchronous) clears the button state and both
//   pipeline valids, and loads the register defaults: active_low 1,
//   debounce 50 ms, click gap 400 ms, hold 1000 ms.
//   The user must write registers over APB at byte addresses 0, 4, 8, 12
//   only while the block is idle, which it does not enforce; pready is tied high.
module button_click_hold_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bchd_pkg::sample_t           s_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bchd_pkg::event_t            m_payload,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bchd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // configuration
    logic        active_low_reg;
    logic [15:0] debounce_ms_reg;
    logic [15:0] click_gap_ms_reg;
    logic [15:0] hold_ms_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg   <= bchd_pkg::RST_ACTIVE_LOW;
            debounce_ms_reg  <= bchd_pkg::RST_DEBOUNCE_MS;
            click_gap_ms_reg <= bchd_pkg::RST_CLICK_GAP_MS;
            hold_ms_reg      <= bchd_pkg::RST_HOLD_MS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bchd_pkg::REG_ACTIVE_LOW:   active_low_reg   <= pwdata[0];
                bchd_pkg::REG_DEBOUNCE_MS:  debounce_ms_reg  <= pwdata[15:0];
                bchd_pkg::REG_CLICK_GAP_MS: click_gap_ms_reg <= pwdata[15:0];
                bchd_pkg::REG_HOLD_MS:      hold_ms_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bchd_pkg::REG_ACTIVE_LOW:   prdata = {31'd0, active_low_reg};
            bchd_pkg::REG_DEBOUNCE_MS:  prdata = {16'd0, debounce_ms_reg};
            bchd_pkg::REG_CLICK_GAP_MS: prdata = {16'd0, click_gap_ms_reg};
            bchd_pkg::REG_HOLD_MS:      prdata = {16'd0, hold_ms_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // input register and output register
    logic              in_valid_reg;
    bchd_pkg::sample_t in_data_reg;
    logic              out_valid_reg;
    bchd_pkg::event_t  out_data_reg;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    // button state
    logic        is_pressed_reg,    is_pressed_next;
    logic [31:0] press_time_reg,    press_time_next;
    logic [31:0] release_time_reg,  release_time_next;
    logic [1:0]  click_count_reg,   click_count_next;
    logic        hold_reported_reg, hold_reported_next;
    logic        idle_reported_reg, idle_reported_next;

    logic             active;
    logic [31:0]      since_rel;
    logic [31:0]      since_press;
    logic [31:0]      hold_ext;
    bchd_pkg::event_t ev;

    assign active      = active_low_reg ? !in_data_reg.pin_level : in_data_reg.pin_level;
    assign since_rel   = in_data_reg.now_ms - release_time_reg;
    assign since_press = in_data_reg.now_ms - press_time_reg;
    assign hold_ext    = {16'd0, hold_ms_reg};

    always_comb begin
        is_pressed_next    = is_pressed_reg;
        press_time_next    = press_time_reg;
        release_time_next  = release_time_reg;
        click_count_next   = click_count_reg;
        hold_reported_next = hold_reported_reg;
        idle_reported_next = idle_reported_reg;
        ev                 = '0;

        if (!is_pressed_reg) begin
            hold_reported_next = 1'b0;
            ev.released_time   = since_rel - hold_ext;
            if (!active && since_rel > hold_ext) begin
                ev.idle_once       = !idle_reported_reg;
                ev.idle_every      = 1'b1;
                idle_reported_next = 1'b1;
            end
            if (!active && since_rel > {16'd0, click_gap_ms_reg}) begin
                // clicks count only when the last press was short
                if (since_press < hold_ext) begin
                    ev.click_one   = (click_count_reg == bchd_pkg::CLICK_ONE);
                    ev.click_two   = (click_count_reg == bchd_pkg::CLICK_TWO);
                    ev.click_three = (click_count_reg == bchd_pkg::CLICK_THREE);
                end
                click_count_next = bchd_pkg::CLICK_NONE;
            end
            if (active && since_rel > {16'd0, debounce_ms_reg}) begin
                is_pressed_next = 1'b1;
                press_time_next = in_data_reg.now_ms;
                ev.rise_edge    = 1'b1;
                if (click_count_reg != bchd_pkg::CLICK_MAX) begin
                    click_count_next = click_count_reg + 2'd1;
                end
            end
        end else begin
            idle_reported_next = 1'b0;
            ev.pressed_now     = 1'b1;
            ev.held_time       = since_press - hold_ext;
            if (active && since_press > hold_ext) begin
                ev.hold_once       = !hold_reported_reg;
                ev.hold_every      = 1'b1;
                hold_reported_next = 1'b1;
            end
            if (!active && since_press > {16'd0, debounce_ms_reg}) begin
                is_pressed_next   = 1'b0;
                release_time_next = in_data_reg.now_ms;
                ev.fall_edge      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            is_pressed_reg    <= 1'b0;
            press_time_reg    <= 32'd0;
            release_time_reg  <= 32'd0;
            click_count_reg   <= bchd_pkg::CLICK_NONE;
            hold_reported_reg <= 1'b0;
            idle_reported_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg     <= 1'b1;
                is_pressed_reg    <= is_pressed_next;
                press_time_reg    <= press_time_next;
                release_time_reg  <= release_time_next;
                click_count_reg   <= click_count_next;
                hold_reported_reg <= hold_reported_next;
                idle_reported_reg <= idle_reported_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_payload;
        end
        if (advance) begin
            out_data_reg <= ev;
        end
    end

endmodule

@@ design/bchd_checker.sv @@
// Checker: port-level assertions on the result channel, bound to the top level.
module bchd_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input bchd_pkg::event_t m_payload
);

    // stalled result transaction stays put
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    a_rise_from_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.rise_edge |-> !m_payload.pressed_now && !m_payload.fall_edge)
        else $error("press edge while already pressed");

    a_fall_from_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.fall_edge |-> m_payload.pressed_now
            && m_payload.released_time == 32'd0)
        else $error("release edge while released");

    a_one_click_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_payload.click_one, m_payload.click_two,
                              m_payload.click_three})
            && !(m_payload.pressed_now && m_payload.click_one))
        else $error("conflicting click report");

    a_once_implies_every: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_payload.hold_once || m_payload.hold_every)
            && (!m_payload.idle_once || m_payload.idle_every))
        else $error("once flag without continuous flag");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

@@ sim/tb_button_click_hold_detector.sv @@
// Testbench for the button click and hold detector: predicting scoreboard plus stream drivers.
module tb_button_click_hold_detector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned LONG_STALL   = 200;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned SETTLE_CYCLES = 4;

    // Tracks button state and register values, predicts one event per sample.
    class click_event_scoreboard;
        logic        cfg_active_low;
        logic [15:0] cfg_debounce;
        logic [15:0] cfg_gap;
        logic [15:0] cfg_hold;

        logic        pressed;
        logic [31:0] t_press;
        logic [31:0] t_release;
        logic [1:0]  clicks;
        logic        hold_seen;
        logic        idle_seen;

        bchd_pkg::event_t expected_events[$];
        int unsigned      errors;

        function new();
            cfg_active_low = bchd_pkg::RST_ACTIVE_LOW;
            cfg_debounce   = bchd_pkg::RST_DEBOUNCE_MS;
            cfg_gap        = bchd_pkg::RST_CLICK_GAP_MS;
            cfg_hold       = bchd_pkg::RST_HOLD_MS;
            pressed        = 1'b0;
            t_press        = '0;
            t_release      = '0;
            clicks         = bchd_pkg::CLICK_NONE;
            hold_seen      = 1'b0;
            idle_seen      = 1'b0;
            errors         = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                bchd_pkg::REG_ACTIVE_LOW:   cfg_active_low = data[0];
                bchd_pkg::REG_DEBOUNCE_MS:  cfg_debounce   = data[15:0];
                bchd_pkg::REG_CLICK_GAP_MS: cfg_gap        = data[15:0];
                bchd_pkg::REG_HOLD_MS:      cfg_hold       = data[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        // Flags use the state held before any edge of this sample.
        function void note_sample(bchd_pkg::sample_t smp);
            bchd_pkg::event_t ev;
            logic             act;
            logic [31:0]      since_rel;
            logic [31:0]      since_press;
            ev          = '0;
            act         = cfg_active_low ? ~smp.pin_level : smp.pin_level;
            since_rel   = smp.now_ms - t_release;
            since_press = smp.now_ms - t_press;
            if (!pressed) begin
                hold_seen        = 1'b0;
                ev.released_time = since_rel - {16'h0, cfg_hold};
                if (!act && since_rel > {16'h0, cfg_hold}) begin
                    if (!idle_seen) begin
                        ev.idle_once = 1'b1;
                        idle_seen    = 1'b1;
                    end
                    ev.idle_every = 1'b1;
                end
                if (!act && since_rel > {16'h0, cfg_gap}) begin
                    // long presses clear the count without a report
                    if (since_press < {16'h0, cfg_hold}) begin
                        case (clicks)
                            bchd_pkg::CLICK_ONE:   ev.click_one   = 1'b1;
                            bchd_pkg::CLICK_TWO:   ev.click_two   = 1'b1;
                            bchd_pkg::CLICK_THREE: ev.click_three = 1'b1;
                            default: ;
                        endcase
                    end
                    clicks = bchd_pkg::CLICK_NONE;
                end
                if (act && since_rel > {16'h0, cfg_debounce}) begin
                    pressed      = 1'b1;
                    t_press      = smp.now_ms;
                    ev.rise_edge = 1'b1;
                    if (clicks < bchd_pkg::CLICK_MAX) clicks = clicks + 2'd1;
                end
            end else begin
                idle_seen      = 1'b0;
                ev.pressed_now = 1'b1;
                ev.held_time   = since_press - {16'h0, cfg_hold};
                if (act && since_press > {16'h0, cfg_hold}) begin
                    if (!hold_seen) begin
                        ev.hold_once = 1'b1;
                        hold_seen    = 1'b1;
                    end
                    ev.hold_every = 1'b1;
                end
                if (!act && since_press > {16'h0, cfg_debounce}) begin
                    pressed      = 1'b0;
                    t_release    = smp.now_ms;
                    ev.fall_edge = 1'b1;
                end
            end
            expected_events.push_back(ev);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_event(bchd_pkg::event_t got);
            bchd_pkg::event_t want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("event with nothing pending: 0x%0h", got));
                return;
            end
            want = expected_events.pop_front();
            compare_field("rise_edge",   32'(got.rise_edge),   32'(want.rise_edge));
            compare_field("fall_edge",   32'(got.fall_edge),   32'(want.fall_edge));
            compare_field("click_one",   32'(got.click_one),   32'(want.click_one));
            compare_field("click_two",   32'(got.click_two),   32'(want.click_two));
            compare_field("click_three", 32'(got.click_three), 32'(want.click_three));
            compare_field("hold_once",   32'(got.hold_once),   32'(want.hold_once));
            compare_field("hold_every",  32'(got.hold_every),  32'(want.hold_every));
            compare_field("idle_once",   32'(got.idle_once),   32'(want.idle_once));
            compare_field("idle_every",  32'(got.idle_every),  32'(want.idle_every));
            compare_field("pressed_now", 32'(got.pressed_now), 32'(want.pressed_now));
            compare_field("released_time", got.released_time, want.released_time);
            compare_field("held_time",     got.held_time,     want.held_time);
        endtask
    endclass

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    bchd_pkg::sample_t           s_payload = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    bchd_pkg::event_t            m_payload;
    logic                        psel      = 1'b0;
    logic                        penable   = 1'b0;
    logic                        pwrite    = 1'b0;
    logic [bchd_pkg::ADDR_W-1:0] paddr     = '0;
    logic [31:0]                 pwdata    = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    click_event_scoreboard sb = new();

    logic        idle_enable   = 1'b1;
    logic        stall_request = 1'b0;
    logic [31:0] clock_ms      = '0;

    button_click_hold_detector DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Tasks below are entered right after a rising edge.
    task send_sample(logic [31:0] now, logic level);
        bchd_pkg::sample_t smp;
        smp.now_ms    = now;
        smp.pin_level = level;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= smp;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        sb.note_sample(smp);
    endtask

    task apb_write(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pready) break;
        end
        sb.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Upper pwdata bits are random; only the register width may take effect.
    task set_config(logic al, logic [15:0] db, logic [15:0] gap, logic [15:0] hold);
        s_valid <= 1'b0;
        wait_drained();
        apb_write(bchd_pkg::REG_ACTIVE_LOW,   {31'($urandom()), al});
        apb_write(bchd_pkg::REG_DEBOUNCE_MS,  {16'($urandom()), db});
        apb_write(bchd_pkg::REG_CLICK_GAP_MS, {16'($urandom()), gap});
        apb_write(bchd_pkg::REG_HOLD_MS,      {16'($urandom()), hold});
    endtask

    // Steps cluster around the debounce, gap and hold thresholds; a few wrap far.
    function automatic int unsigned pick_delta();
        int unsigned db;
        int unsigned gap;
        int unsigned hold;
        db   = sb.cfg_debounce;
        gap  = sb.cfg_gap;
        hold = sb.cfg_hold;
        case ($urandom_range(0, 19))
            0, 1, 2, 3:     return $urandom_range(0, db + 2);
            4, 5, 6, 7:     return $urandom_range(0, gap + 2);
            8, 9, 10, 11, 12: return $urandom_range(0, hold + hold / 2 + 2);
            13, 14: begin
                case ($urandom_range(0, 5))
                    0: return db;
                    1: return db + 1;
                    2: return gap;
                    3: return gap + 1;
                    4: return hold;
                    default: return hold + 1;
                endcase
            end
            15, 16, 17: return $urandom_range(0, 3);
            18: return hold + gap + $urandom_range(1, 100);
            default: return $urandom();
        endcase
    endfunction

    // Runs of pressed and released samples with occasional bounce flips.
    task run_gestures(int unsigned n_items);
        int unsigned left;
        int unsigned run;
        logic        level;
        logic        lvl;
        left  = n_items;
        level = sb.cfg_active_low;
        while (left > 0) begin
            run = $urandom_range(1, 5);
            while (run > 0 && left > 0) begin
                lvl      = ($urandom_range(0, 9) == 0) ? ~level : level;
                clock_ms = clock_ms + pick_delta();
                send_sample(clock_ms, lvl);
                run--;
                left--;
            end
            level = ~level;
        end
    endtask

    task send_at(logic [31:0] now, logic level);
        send_sample(now, level);
    endtask

    task run_directed();
        // reset polarity: pin low is the pressed level
        send_at(32'd0,    1'b1);
        send_at(32'd10,   1'b0);  // inside debounce window
        send_at(32'd60,   1'b0);  // press
        send_at(32'd120,  1'b1);
        send_at(32'd200,  1'b0);
        send_at(32'd300,  1'b1);
        send_at(32'd400,  1'b0);
        send_at(32'd500,  1'b1);
        send_at(32'd600,  1'b0);  // count saturates
        send_at(32'd700,  1'b1);
        send_at(32'd1200, 1'b1);  // triple
        send_at(32'd1300, 1'b0);
        send_at(32'd1400, 1'b1);
        send_at(32'd1900, 1'b1);  // single
        send_at(32'd2000, 1'b0);
        send_at(32'd2100, 1'b1);
        send_at(32'd2200, 1'b0);
        send_at(32'd2300, 1'b1);
        send_at(32'd2800, 1'b1);  // double
        send_at(32'd3000, 1'b0);
        send_at(32'd4100, 1'b0);  // hold
        send_at(32'd4300, 1'b1);
        send_at(32'd4800, 1'b1);  // long press: cleared silently
        send_at(32'd5400, 1'b1);  // not-held
        send_at(32'hFFFF_FFFF, 1'b0);
        send_at(32'h0000_0040, 1'b1);  // release across the wrap
        clock_ms = 32'h0000_0040;
    endtask

    // result side: checks and random back-pressure, plus one long hold-off
    initial begin
        int unsigned burst_left;
        int unsigned long_left;
        burst_left = 0;
        long_left  = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_event(m_payload);
            if (long_left > 0) begin
                long_left--;
                m_ready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                long_left     = LONG_STALL - 1;
                m_ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                m_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no transaction on any port
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        set_config(1'b0, 16'd0, 16'd0, 16'd0);
        run_gestures(PHASE_ITEMS);

        set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_gestures(PHASE_ITEMS);

        set_config(1'($urandom()), 16'($urandom_range(0, 80)),
                   16'($urandom_range(100, 600)), 16'($urandom_range(300, 1500)));
        stall_request = 1'b1;
        run_gestures(PHASE_ITEMS);

        set_config(1'b0, 16'd20, 16'd300, 16'd800);
        run_gestures(PHASE_ITEMS);

        set_config(1'($urandom()), 16'($urandom_range(0, 200)),
                   16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)));
        clock_ms = $urandom();
        run_gestures(PHASE_ITEMS);

        set_config(1'b1, bchd_pkg::RST_DEBOUNCE_MS, bchd_pkg::RST_CLICK_GAP_MS,
                   bchd_pkg::RST_HOLD_MS);
        idle_enable = 1'b0;
        run_gestures(PHASE_ITEMS);
        s_valid <= 1'b0;

        wait_drained();
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
